// ----- rtl/pstk_pkg.sv -----
// ----------------------------------------------------------------------------
// pstk_pkg
// Shared types, constants and helpers of the postfix stack evaluator.
// ----------------------------------------------------------------------------
`default_nettype none
package pstk_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int FRAC_BITS   = 16;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int NUM_W       = 32 + FRAC_BITS;
    localparam int DCNT_W      = $clog2(NUM_W + 1);

    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_MISSING    = 3'd1;
    localparam logic [2:0] ST_OVERFLOW   = 3'd2;
    localparam logic [2:0] ST_DIVZERO    = 3'd3;
    localparam logic [2:0] ST_INCOMPLETE = 3'd4;
    localparam logic [2:0] ST_ILLEGAL    = 3'd5;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] operand;
        logic               last;
    } tok_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         status;
    } res_t;

    // clamp a 64-bit signed value to the 32-bit range
    function automatic logic signed [31:0] sat64(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (x < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/pstk_ram.sv -----
// ----------------------------------------------------------------------------
// pstk_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module pstk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/pstk_div.sv -----
// ----------------------------------------------------------------------------
// pstk_div
// Iterative restoring divider: sat((a * 2^FRAC_BITS) / b), toward zero.
// ----------------------------------------------------------------------------
`default_nettype none
module pstk_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [31:0] a,
    input  wire logic signed [31:0] b,
    output logic                    done,
    output logic signed [31:0]      quot
);

    logic [pstk_pkg::NUM_W-1:0]  num_reg, num_next;
    logic [31:0]                 rem_reg, rem_next;
    logic [31:0]                 den_reg, den_next;
    logic                        neg_reg, neg_next;
    logic [pstk_pkg::DCNT_W-1:0] cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [32:0]                 trial;
    logic                        qbit;
    logic [31:0]                 mag_a, mag_b;
    logic signed [63:0]          qs;

    assign mag_a = a[31] ? 32'(-a) : 32'(a);
    assign mag_b = b[31] ? 32'(-b) : 32'(b);
    assign trial = {rem_reg, num_reg[pstk_pkg::NUM_W-1]};
    assign qbit  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = pstk_pkg::NUM_W'(mag_a) << pstk_pkg::FRAC_BITS;
            rem_next  = '0;
            den_next  = mag_b;
            neg_next  = a[31] ^ b[31];
            cnt_next  = pstk_pkg::DCNT_W'(pstk_pkg::NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
            num_next = {num_reg[pstk_pkg::NUM_W-2:0], qbit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == pstk_pkg::DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign qs   = neg_reg ? -$signed(64'(num_reg)) : $signed(64'(num_reg));
    assign quot = pstk_pkg::sat64(qs);
    assign done = done_reg;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !done_reg)
        else $error("divider done while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without run");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= pstk_pkg::DCNT_W'(pstk_pkg::NUM_W))
        else $error("divider count out of range");
`endif

endmodule
`default_nettype wire

// ----- rtl/postfix_stack_evaluator_core.sv -----
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_core
// Postfix evaluator over signed Q16.16 tokens with a RAM-held operand stack.
// ----------------------------------------------------------------------------
// One token per transfer on tok. Each token runs S_IDLE and S_FIN; an operator
// with two entries and no error adds S_READ, a multiply S_MUL, a divide S_DIV
// (bit-serial divider, 48-bit numerator at Q16.16). The top of stack sits in
// a register, the entries below it in a one-port-read RAM, so an operator
// needs one RAM read. On the last token one result transfers on res (value
// zero unless status is ok) and stack and status clear; a waiting result does
// not stop further tokens, only the next last token waits for the output slot.
// ----------------------------------------------------------------------------
`default_nettype none
module postfix_stack_evaluator_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             tok_valid,
    output logic                  tok_ready,
    input  wire pstk_pkg::tok_t   tok,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output pstk_pkg::res_t        res
);

    typedef enum logic [2:0] {S_IDLE, S_READ, S_MUL, S_DIV, S_FIN} state_t;

    state_t                     state_reg, state_next;
    logic [pstk_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [2:0]                 err_reg, err_next;
    logic signed [31:0]         tos_reg, tos_next;
    pstk_pkg::tok_t             tok_reg, tok_next;
    logic signed [63:0]         prod_reg, prod_next;
    logic                       res_valid_reg, res_valid_next;
    pstk_pkg::res_t             res_reg, res_next;

    // stack RAM, entries below the top of stack
    logic                       ram_we;
    logic [pstk_pkg::PTR_W-1:0] ram_waddr, ram_raddr;
    logic [31:0]                ram_rdata;
    logic signed [31:0]         opa;
    logic                       div_start, div_done;
    logic signed [31:0]         div_quot;
    logic [2:0]                 fin_status;

    assign ram_waddr = pstk_pkg::PTR_W'(cnt_reg - 1'b1);
    assign ram_raddr = pstk_pkg::PTR_W'(cnt_reg - 2'd2);
    assign opa       = $signed(ram_rdata);

    pstk_ram #(.WIDTH(32), .DEPTH(pstk_pkg::STACK_DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (tos_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pstk_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .a     (opa),
        .b     (tos_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        if (err_reg != pstk_pkg::ST_OK)
            fin_status = err_reg;
        else if (cnt_reg != pstk_pkg::CNT_W'(1))
            fin_status = pstk_pkg::ST_INCOMPLETE;
        else
            fin_status = pstk_pkg::ST_OK;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        err_next       = err_reg;
        tos_next       = tos_reg;
        tok_next       = tok_reg;
        prod_next      = prod_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        ram_we         = 1'b0;
        div_start      = 1'b0;
        tok_ready      = (state_reg == S_IDLE);

        if (res_valid_reg && res_ready)
            res_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (tok_valid)
                begin
                    tok_next   = tok;
                    state_next = S_FIN;
                    if (err_reg != pstk_pkg::ST_OK)
                    begin
                        // sticky error: stack left alone
                    end
                    else if (tok.func == pstk_pkg::OP_PUSH)
                    begin
                        if (cnt_reg >= pstk_pkg::CNT_W'(pstk_pkg::STACK_DEPTH))
                            err_next = pstk_pkg::ST_OVERFLOW;
                        else
                        begin
                            ram_we   = (cnt_reg != '0);
                            tos_next = tok.operand;
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    else if (tok.func > pstk_pkg::OP_DIV)
                        err_next = pstk_pkg::ST_ILLEGAL;
                    else if (cnt_reg < pstk_pkg::CNT_W'(2))
                        err_next = pstk_pkg::ST_MISSING;
                    else
                        state_next = S_READ;
                end
            end
            S_READ:
            begin
                // opa = entry below top, tos_reg = b
                unique case (tok_reg.func)
                    pstk_pkg::OP_ADD:
                    begin
                        tos_next   = pstk_pkg::sat64(64'(opa) + 64'(tos_reg));
                        cnt_next   = cnt_reg - 1'b1;
                        state_next = S_FIN;
                    end
                    pstk_pkg::OP_SUB:
                    begin
                        tos_next   = pstk_pkg::sat64(64'(opa) - 64'(tos_reg));
                        cnt_next   = cnt_reg - 1'b1;
                        state_next = S_FIN;
                    end
                    pstk_pkg::OP_MUL:
                    begin
                        prod_next  = opa * tos_reg;
                        state_next = S_MUL;
                    end
                    default:
                    begin
                        if (tos_reg == '0)
                        begin
                            err_next   = pstk_pkg::ST_DIVZERO;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                endcase
            end
            S_MUL:
            begin
                // arithmetic shift rounds toward minus infinity
                tos_next   = pstk_pkg::sat64(prod_reg >>> pstk_pkg::FRAC_BITS);
                cnt_next   = cnt_reg - 1'b1;
                state_next = S_FIN;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    tos_next   = div_quot;
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!tok_reg.last)
                    state_next = S_IDLE;
                else if (!res_valid_reg || res_ready)
                begin
                    res_valid_next = 1'b1;
                    res_next.status = fin_status;
                    res_next.value  = (fin_status == pstk_pkg::ST_OK) ? tos_reg : '0;
                    cnt_next   = '0;
                    err_next   = pstk_pkg::ST_OK;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            err_reg       <= pstk_pkg::ST_OK;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            err_reg       <= err_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg  <= tos_next;
        tok_reg  <= tok_next;
        prod_reg <= prod_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= pstk_pkg::CNT_W'(pstk_pkg::STACK_DEPTH))
        else $error("stack count beyond depth");
    a_read_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (err_reg == pstk_pkg::ST_OK
            && cnt_reg >= pstk_pkg::CNT_W'(2)))
        else $error("operator issued with error or short stack");
    a_err_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.status != pstk_pkg::ST_OK) |-> (res_reg.value == '0))
        else $error("error result carries a value");
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside divide state");
`endif

endmodule
`default_nettype wire
